// ===== rtl/flow_hash_queue_select_top_assert.svh =====
// Assertion macros shared by the flow hash queue select RTL.
// They expect clk and rst_n to be visible where they are used.
`ifndef FLOW_HASH_QUEUE_SELECT_TOP_ASSERT_SVH
`define FLOW_HASH_QUEUE_SELECT_TOP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FHQS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds at every clock edge outside of reset.
`define FHQS_ASSERT_ALWAYS(label, cond, msg) \
  `FHQS_ASSERT_IMPLIES(label, 1'b1, cond, msg)

`endif

// ===== rtl/fhqs_pkg.sv =====
`timescale 1ns / 1ps

package fhqs_pkg;

  // Transport and network header kinds.
  localparam logic [1:0] L4_UDP  = 2'd1;
  localparam logic [1:0] L4_TCP  = 2'd2;
  localparam logic [1:0] L3_IPV4 = 2'd1;
  localparam logic [1:0] L3_IPV6 = 2'd2;

  // Bit positions in hash_protocols.
  localparam int HP_IPV4_UDP = 0;
  localparam int HP_IPV6_UDP = 1;
  localparam int HP_IPV4_TCP = 2;
  localparam int HP_IPV6_TCP = 3;
  localparam int HP_IPV4     = 4;
  localparam int HP_IPV6     = 5;

  // Configuration register map.
  localparam int         CFG_AW             = 3;
  localparam logic       REG_HASH_PROTOCOLS = 1'b0;
  localparam logic       REG_QUEUE_COUNT    = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

  // Longest key: four port bytes and two IPv6 addresses.
  localparam int KEY_W      = 288;
  localparam int NUM_GRP    = 8;
  localparam int GRP_W      = KEY_W / NUM_GRP;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = 32 / DIV_BITS;
  localparam int NSTG       = 3 + DIV_STAGES;

  typedef struct packed {
    logic [1:0]  l4_kind;
    logic [1:0]  l3_kind;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [5:0]  tx_queue_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0] dest_queue;
  } out_item_t;

  // CRC contribution of a single set key bit. The key is right aligned, so bit
  // pos sits in a byte that is followed by pos/8 more bytes. Leading zero bytes
  // leave a zero-initialized CRC untouched, which makes this independent of the
  // key length. Only evaluated at elaboration.
  function automatic logic [31:0] crc_bit_mask(input int unsigned pos);
    logic [31:0] c;
    int unsigned nsh;
    c   = 32'(1) << pos[2:0];
    nsh = ((pos >> 3) + 1) << 3;
    for (int unsigned k = 0; k < nsh; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/fhqs_in_if.sv =====
`timescale 1ns / 1ps

interface fhqs_in_if import fhqs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fhqs_out_if.sv =====
`timescale 1ns / 1ps

interface fhqs_out_if import fhqs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/flow_hash_queue_select_top.sv =====
// Picks a receive queue per packet descriptor: the CRC32C (reflected, init 0,
// no final inversion) of the enabled ports and addresses, taken modulo the
// queue count, or the sending queue index modulo the count when no hash
// protocol is enabled. One transaction is accepted every clock cycle unless
// an output stall has filled the pipeline, and its result passes through
// seven register stages: three that fold the 288-bit key into a CRC through
// a registered XOR tree and four that each retire 8 dividend bits of the
// remainder. A stall at the output holds the pipeline without loss, and
// bubbles are squeezed out. Write the registers only while the block is empty.
`timescale 1ns / 1ps

`include "flow_hash_queue_select_top_assert.svh"

module flow_hash_queue_select_top import fhqs_pkg::*; #(
  parameter int MAX_QUEUE_COUNT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  fhqs_in_if.sink           in_ch,
  fhqs_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Effective count never exceeds the 7-bit register or the parameter.
  localparam int NW = ($clog2(MAX_QUEUE_COUNT + 1) > 7) ? 7 : $clog2(MAX_QUEUE_COUNT + 1);

  // ---------------- configuration ----------------
  logic [5:0]    hash_r;
  logic [6:0]    qcount_r;
  logic [NW-1:0] eff_n_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[CFG_AW-1] == REG_QUEUE_COUNT) ? 32'(qcount_r) : 32'(hash_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      qcount_r <= 7'd1;
      eff_n_r  <= NW'(1);
    end else if (cfg_wr) begin
      if (paddr[CFG_AW-1] == REG_HASH_PROTOCOLS) begin
        hash_r <= pwdata[5:0];
      end else begin
        qcount_r <= pwdata[6:0];
        if (pwdata[6:0] == 7'd0) begin
          eff_n_r <= NW'(1);
        end else if (int'(pwdata[6:0]) > MAX_QUEUE_COUNT) begin
          eff_n_r <= NW'(MAX_QUEUE_COUNT);
        end else begin
          eff_n_r <= NW'(pwdata[6:0]);
        end
      end
    end
  end

  // ---------------- handshake ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] stg_rdy;
  logic [NSTG-1:0] vld_up;

  always_comb begin
    stg_rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_rdy[k] = !vld_r[k] || stg_rdy[k+1];
    end
    vld_up  = {vld_r[NSTG-2:0], in_ch.valid};
    vld_nxt = (stg_rdy & vld_up) | (~stg_rdy & vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = stg_rdy[0];

  // ---------------- stage 1: key placement ----------------
  logic             use_ports;
  logic             use_v4;
  logic             use_v6;
  logic [31:0]      ports_sel;
  logic [KEY_W-1:0] key_nxt;
  logic [KEY_W-1:0] s1_key_r;
  logic             s1_off_r;
  logic [5:0]       s1_txq_r;

  // Key bytes are right aligned; the zero bytes in front do not move the CRC.
  always_comb begin
    use_ports = ((hash_r[HP_IPV4_UDP] || hash_r[HP_IPV6_UDP]) && in_ch.data.l4_kind == L4_UDP)
             || ((hash_r[HP_IPV4_TCP] || hash_r[HP_IPV6_TCP]) && in_ch.data.l4_kind == L4_TCP);
    use_v4    = hash_r[HP_IPV4] && in_ch.data.l3_kind == L3_IPV4;
    use_v6    = hash_r[HP_IPV6] && in_ch.data.l3_kind == L3_IPV6;
    ports_sel = use_ports ? {in_ch.data.l4_sport, in_ch.data.l4_dport} : '0;
    key_nxt   = '0;
    if (use_v4) begin
      key_nxt[95:0] = {ports_sel, in_ch.data.src_addr_lo[31:0], in_ch.data.dst_addr_lo[31:0]};
    end else if (use_v6) begin
      key_nxt = {ports_sel, in_ch.data.src_addr_hi, in_ch.data.src_addr_lo,
                 in_ch.data.dst_addr_hi, in_ch.data.dst_addr_lo};
    end else begin
      key_nxt[31:0] = ports_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      s1_key_r <= key_nxt;
      s1_off_r <= (hash_r == '0);
      s1_txq_r <= in_ch.data.tx_queue_index;
    end
  end

  // ---------------- stage 2: partial XOR groups ----------------
  logic [31:0] contrib  [KEY_W];
  logic [31:0] part_nxt [NUM_GRP];
  logic [31:0] s2_part_r [NUM_GRP];
  logic        s2_off_r;
  logic [5:0]  s2_txq_r;

  for (genvar i = 0; i < KEY_W; i++) begin : g_mask
    localparam logic [31:0] MASK = crc_bit_mask(i);
    assign contrib[i] = s1_key_r[i] ? MASK : '0;
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      part_nxt[g] = '0;
      for (int e = 0; e < GRP_W; e++) begin
        part_nxt[g] = part_nxt[g] ^ contrib[g*GRP_W + e];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[1]) begin
      s2_part_r <= part_nxt;
      s2_off_r  <= s1_off_r;
      s2_txq_r  <= s1_txq_r;
    end
  end

  // ---------------- stage 3: CRC and dividend ----------------
  logic [31:0] crc_nxt;
  logic [31:0] s3_dvd_r;

  always_comb begin
    crc_nxt = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      crc_nxt = crc_nxt ^ s2_part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_rdy[2]) begin
      s3_dvd_r <= s2_off_r ? 32'(s2_txq_r) : crc_nxt;
    end
  end

  // ---------------- stages 4 to 7: remainder ----------------
  // Restoring remainder, one dividend byte per stage, most significant first.
  function automatic logic [NW-1:0] rem_byte(input logic [NW-1:0] r, input logic [7:0] b,
                                             input logic [NW-1:0] n);
    logic [NW:0]   t;
    logic [NW-1:0] acc;
    acc = r;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      t = {acc, b[i]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      acc = t[NW-1:0];
    end
    return acc;
  endfunction

  logic [NW-1:0] div_rem_r [DIV_STAGES];
  logic [31:0]   div_dvd_r [DIV_STAGES];

  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    logic [NW-1:0] src_rem;
    logic [31:0]   src_dvd;

    if (d == 0) begin : g_first
      assign src_rem = '0;
      assign src_dvd = s3_dvd_r;
    end else begin : g_next
      assign src_rem = div_rem_r[d-1];
      assign src_dvd = div_dvd_r[d-1];
    end

    always_ff @(posedge clk) begin
      if (stg_rdy[3+d]) begin
        div_rem_r[d] <= rem_byte(src_rem, src_dvd[31 - DIV_BITS*d -: DIV_BITS], eff_n_r);
        div_dvd_r[d] <= src_dvd;
      end
    end
  end

  assign out_ch.valid           = vld_r[NSTG-1];
  assign out_ch.data.dest_queue = 6'(div_rem_r[DIV_STAGES-1]);

  // ---------------- assertions ----------------
  `FHQS_ASSERT_IMPLIES(a_ready_chain, out_ch.ready, in_ch.ready,
    "input not ready although the output side is ready")
  `FHQS_ASSERT_IMPLIES(a_stall_only_full, !in_ch.ready, &vld_r,
    "input stalled while the pipeline has an empty stage")
  `FHQS_ASSERT_ALWAYS(a_eff_count, eff_n_r != '0 && int'(eff_n_r) <= MAX_QUEUE_COUNT,
    "effective queue count out of range")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fhqs_pkg::*;

  localparam int QUEUE_LIMIT = 64;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES = 12;

  localparam logic [CFG_AW-1:0] ADDR_HASH_PROTOCOLS = CFG_AW'({REG_HASH_PROTOCOLS, 2'b00});
  localparam logic [CFG_AW-1:0] ADDR_QUEUE_COUNT    = CFG_AW'({REG_QUEUE_COUNT, 2'b00});

  // Register settings for the first random phases; later phases draw at random.
  localparam int HP_PICKS[8] = '{63, 0, 1, 2, 4, 8, 16, 32};
  localparam int QC_PICKS[8] = '{127, 0, 64, 1, 65, 3, 63, 2};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  fhqs_in_if  in_ch ();
  fhqs_out_if out_ch ();

  flow_hash_queue_select_top #(
    .MAX_QUEUE_COUNT(QUEUE_LIMIT)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Local copy of the register file, used by the predictor.
  logic [5:0] cfg_hash_protocols;
  logic [6:0] cfg_queue_count;

  in_item_t   pkt_backlog[$];
  logic [5:0] dest_predictions[$];

  int  sender_idle_pct;
  int  recv_stall_pct;
  logic in_fire;
  int  n_queued;
  int  n_accepted;
  int  n_results;
  int  n_mismatches;
  int  n_settings;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d of %0d descriptors accepted", n_accepted, n_queued);
    $display("flow_hash_queue_select_top test failed");
    $finish;
  end

  function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] b);
    crc ^= {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    return crc;
  endfunction

  // Feeds the low nbytes of v into the CRC, most significant byte first.
  function automatic logic [31:0] crc32c_wire(logic [31:0] crc, logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      crc = crc32c_byte(crc, v[8*i +: 8]);
    end
    return crc;
  endfunction

  function automatic logic [5:0] select_queue(in_item_t it);
    logic [31:0] crc;
    logic [31:0] modulus;
    logic [31:0] q;
    logic        udp_on;
    logic        tcp_on;
    crc = '0;
    modulus = 32'(cfg_queue_count);
    if (modulus == 0) modulus = 1;
    if (modulus > QUEUE_LIMIT) modulus = QUEUE_LIMIT;
    udp_on = cfg_hash_protocols[HP_IPV4_UDP] | cfg_hash_protocols[HP_IPV6_UDP];
    tcp_on = cfg_hash_protocols[HP_IPV4_TCP] | cfg_hash_protocols[HP_IPV6_TCP];
    if (cfg_hash_protocols == '0) begin
      q = 32'(it.tx_queue_index) % modulus;
    end else begin
      // Port hashing follows the enable bits of either IP version.
      if ((udp_on && it.l4_kind == L4_UDP) || (tcp_on && it.l4_kind == L4_TCP)) begin
        crc = crc32c_wire(crc, 64'(it.l4_sport), 2);
        crc = crc32c_wire(crc, 64'(it.l4_dport), 2);
      end
      if (cfg_hash_protocols[HP_IPV4] && it.l3_kind == L3_IPV4) begin
        crc = crc32c_wire(crc, 64'(it.src_addr_lo[31:0]), 4);
        crc = crc32c_wire(crc, 64'(it.dst_addr_lo[31:0]), 4);
      end else if (cfg_hash_protocols[HP_IPV6] && it.l3_kind == L3_IPV6) begin
        crc = crc32c_wire(crc, it.src_addr_hi, 8);
        crc = crc32c_wire(crc, it.src_addr_lo, 8);
        crc = crc32c_wire(crc, it.dst_addr_hi, 8);
        crc = crc32c_wire(crc, it.dst_addr_lo, 8);
      end
      q = crc % modulus;
    end
    return q[5:0];
  endfunction

  function automatic logic [15:0] random_port();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_descriptor();
    in_item_t it;
    it.l4_kind        = 2'($urandom_range(3));
    it.l3_kind        = 2'($urandom_range(3));
    it.l4_sport       = random_port();
    it.l4_dport       = random_port();
    it.src_addr_hi    = {$urandom, $urandom};
    it.src_addr_lo    = {$urandom, $urandom};
    it.dst_addr_hi    = {$urandom, $urandom};
    it.dst_addr_lo    = {$urandom, $urandom};
    it.tx_queue_index = 6'($urandom_range(63));
    return it;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    n_mismatches++;
    if (n_mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  task automatic queue_descriptor(in_item_t it);
    pkt_backlog.push_back(it);
    n_queued++;
  endtask

  // Every queued descriptor must be accepted and every result returned.
  task automatic wait_idle();
    while (n_accepted != n_queued || dest_predictions.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a readback of the same register.
  task automatic set_reg(logic [CFG_AW-1:0] addr, logic [31:0] value);
    logic [31:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_HASH_PROTOCOLS) begin
      cfg_hash_protocols = value[5:0];
      want = 32'(cfg_hash_protocols);
    end else begin
      cfg_queue_count = value[6:0];
      want = 32'(cfg_queue_count);
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) note_mismatch("register readback", want, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(logic [31:0] hash_protocols, logic [31:0] queue_count);
    wait_idle();
    set_reg(ADDR_HASH_PROTOCOLS, hash_protocols);
    set_reg(ADDR_QUEUE_COUNT, queue_count);
    n_settings++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // Input driver and output ready, both updated on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_fire) begin
        if (pkt_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_ch.data  <= pkt_backlog.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result transaction, then predicts for each accepted input.
  always @(posedge clk) begin
    logic [5:0] want_q;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (dest_predictions.size() == 0) begin
        note_mismatch("unexpected dest_queue", 32'hFFFF_FFFF, 32'(out_ch.data.dest_queue));
      end else begin
        want_q = dest_predictions.pop_front();
        if (out_ch.data.dest_queue !== want_q) begin
          note_mismatch("dest_queue", 32'(want_q), 32'(out_ch.data.dest_queue));
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      dest_predictions.push_back(select_queue(in_ch.data));
      n_accepted++;
    end
  end

  initial begin
    in_item_t it;
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    in_fire      = 1'b0;
    n_queued     = 0;
    n_accepted   = 0;
    n_results    = 0;
    n_mismatches = 0;
    n_settings   = 1;
    cfg_hash_protocols = '0;
    cfg_queue_count    = 7'd1;
    set_idling(0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: hashing off and a single queue.
    queue_descriptor('0);
    queue_descriptor('1);

    // Every header kind combination with all protocols on, alternating all-ones content.
    configure(63, 64);
    for (int k4 = 0; k4 < 4; k4++) begin
      for (int k3 = 0; k3 < 4; k3++) begin
        it = random_descriptor();
        if ((k4 + k3) % 2 == 0) it = '1;
        it.l4_kind = 2'(k4);
        it.l3_kind = 2'(k3);
        queue_descriptor(it);
      end
    end

    // Hashing off: the sending queue index passes straight through.
    configure(0, 64);
    it = random_descriptor();
    it.tx_queue_index = '0;
    queue_descriptor(it);
    it.tx_queue_index = '1;
    queue_descriptor(it);

    // Port enables for one IP version apply to packets of the other one.
    configure((1 << HP_IPV4_UDP) | (1 << HP_IPV6_TCP), 37);
    it = random_descriptor();
    it.l4_kind = L4_UDP;
    it.l3_kind = L3_IPV6;
    queue_descriptor(it);
    it.l4_kind = L4_TCP;
    it.l3_kind = L3_IPV4;
    queue_descriptor(it);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 8) configure(HP_PICKS[p], QC_PICKS[p]);
      else configure($urandom_range(63), $urandom_range(1, QUEUE_LIMIT));
      set_idling(p % 4);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) queue_descriptor(random_descriptor());
    end

    wait_idle();
    $display("Sent %0d packet descriptors under %0d register settings and four idling patterns;",
             n_queued, n_settings);
    $display("checked %0d queue selections, %0d mismatches", n_results, n_mismatches);
    if (n_mismatches == 0 && dest_predictions.size() == 0) begin
      $display("flow_hash_queue_select_top test passed");
    end else begin
      $display("flow_hash_queue_select_top test failed");
    end
    $finish;
  end

endmodule
